FILE: rtl/core/dmnc_pkg.sv
// dmnc_pkg: shared types, codes and helper functions of the coherence node controller
// no dependencies; used by the controller top level
package dmnc_pkg;

  typedef enum logic [3:0] {
    CMD_READ_REQUEST   = 4'd0,
    CMD_WRITE_REQUEST  = 4'd1,
    CMD_REPLY_RD       = 4'd2,
    CMD_REPLY_WR       = 4'd3,
    CMD_REPLY_ID       = 4'd4,
    CMD_INV            = 4'd5,
    CMD_UPGRADE        = 4'd6,
    CMD_WB_INVALIDATE  = 4'd7,
    CMD_WRITEBACK_INT  = 4'd8,
    CMD_FLUSH          = 4'd9,
    CMD_FLUSH_INVACK   = 4'd10,
    CMD_EVICT_SHARED   = 4'd11,
    CMD_EVICT_MODIFIED = 4'd12,
    CMD_LOCAL_READ     = 4'd13,
    CMD_LOCAL_WRITE    = 4'd14
  } cmd_e;

  typedef enum logic [1:0] {
    LST_M = 2'd0,
    LST_E = 2'd1,
    LST_S = 2'd2,
    LST_I = 2'd3
  } line_st_e;

  typedef enum logic [1:0] {
    DIR_EM = 2'd0,
    DIR_S  = 2'd1,
    DIR_U  = 2'd2
  } dir_st_e;

  localparam logic [7:0] ADDR_NONE  = 8'hFF;
  localparam logic [7:0] MEM_STRIDE = 8'd20;

  typedef struct packed {
    cmd_e        typ;
    logic [1:0]  dest;
    logic [7:0]  addr;
    logic [7:0]  val;
    logic [3:0]  shr;
    logic [1:0]  sr;
    logic [1:0]  ds;
  } msg_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] val;
    line_st_e   st;
  } line_t;

  typedef struct packed {
    dir_st_e    st;
    logic [3:0] bits;
  } dir_t;

  function automatic logic [1:0] lowest_node(input logic [3:0] bits);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (bits[i]) r = 2'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] count_bits(input logic [3:0] bits);
    return 3'(bits[0]) + 3'(bits[1]) + 3'(bits[2]) + 3'(bits[3]);
  endfunction

endpackage

FILE: rtl/core/directory_mesi_node_controller.sv
// directory_mesi_node_controller: cache, home memory and directory of one mesi node
// depends on dmnc_pkg for message, line and directory types
//
// flow: a request is registered at accept, processed in the next cycle, and its
//   first message shows in the cycle after that; messages then follow one per cycle
// each request gives 0 to 4 messages and the next waits for them; busy_o covers the
//   processing cycle and the output buffer drain, the receiver cannot stall
// reset: cache lines invalid at address 0xff, directory all U with no sharers,
//   home memory reads index + 20 * node_id until written, node_id 0
module directory_mesi_node_controller #(
  parameter int NODE_COUNT       = 4,
  parameter int CACHE_LINE_COUNT = 4,
  parameter int MEMORY_BLOCKS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i,
  // request side
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [3:0]            command_i,
  input  logic [1:0]            sender_i,
  input  logic [7:0]            address_i,
  input  logic [7:0]            data_value_i,
  input  logic [3:0]            sharers_i,
  input  logic [1:0]            second_receiver_i,
  input  logic [1:0]            reply_dir_state_i,
  // outgoing messages
  output logic                  out_valid_o,
  output logic [3:0]            out_type_o,
  output logic [1:0]            destination_o,
  output logic [7:0]            out_address_o,
  output logic [7:0]            out_value_o,
  output logic [3:0]            out_sharers_o,
  output logic [1:0]            out_second_receiver_o,
  output logic [1:0]            out_dir_state_o,
  output logic                  last_o
);
  import dmnc_pkg::*;

  localparam int BLK_W  = (MEMORY_BLOCKS > 1) ? $clog2(MEMORY_BLOCKS) : 1;
  localparam int LINE_W = (CACHE_LINE_COUNT > 1) ? $clog2(CACHE_LINE_COUNT) : 1;
  localparam logic [3:0] NODE_MASK =
    (NODE_COUNT >= 4) ? 4'hF : 4'((1 << NODE_COUNT) - 1);

  // one-hot sharer bit of a node, limited to the nodes that exist
  function automatic logic [3:0] node_bit(input logic [1:0] n);
    return (4'b0001 << n) & NODE_MASK;
  endfunction

  // node id reg; host must write it only while no request is in flight, not enforced
  logic [1:0] node_id_q;
  assign cfg_ready_o = 1'b1;

  // request register
  logic       in_valid_q;
  logic [3:0] cmd_q;
  logic [1:0] snd_q, sr_q, rds_q;
  logic [7:0] addr_q, data_q;
  logic [3:0] shr_q;

  // node state
  line_t      line_q [CACHE_LINE_COUNT];
  dir_t       dir_q  [MEMORY_BLOCKS];
  logic [7:0] mem_q  [MEMORY_BLOCKS];
  logic       memv_q [MEMORY_BLOCKS];
  logic       waiting_q, waiting_d;
  logic [7:0] pend_q, pend_d;

  // outgoing message buffer
  msg_t       obuf_q [4];
  logic [2:0] left_q;
  logic [1:0] optr_q;

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = in_valid_q || (left_q != 3'd0);

  // block and line index by small lookup of address bits 3:0, for counts up to 16
  logic [BLK_W-1:0]  blk;
  logic [LINE_W-1:0] li;
  always_comb begin
    blk = '0;
    li  = '0;
    for (int k = 0; k < 16; k++) begin
      if (addr_q[3:0] == 4'(k)) begin
        blk = BLK_W'((k % MEMORY_BLOCKS));
        li  = LINE_W'(((k % MEMORY_BLOCKS) % CACHE_LINE_COUNT));
      end
    end
  end

  line_t      line_cur, line_d;
  dir_t       dir_cur, dir_d;
  logic [7:0] mem_rd, mem_wdata;
  logic       mem_we;
  logic [3:0] home;
  logic       hit;
  logic       ev_need;
  msg_t       ev_msg;
  msg_t       msgs [4];
  logic [2:0] n;
  logic [3:0] other;
  logic [3:0] left_bits;

  assign line_cur = line_q[li];
  assign dir_cur  = dir_q[blk];
  assign home     = addr_q[7:4];
  assign hit      = (line_cur.addr == addr_q) && (line_cur.st != LST_I);
  assign mem_rd   = memv_q[blk] ? mem_q[blk]
                    : (8'(blk) + MEM_STRIDE * {6'd0, node_id_q});

  // eviction notice for a different valid line in the target slot
  always_comb begin
    ev_need = (line_cur.addr != addr_q) && (line_cur.st != LST_I);
    ev_msg  = '0;
    ev_msg.dest = line_cur.addr[5:4];
    ev_msg.addr = line_cur.addr;
    if (line_cur.st == LST_M) begin
      ev_msg.typ = CMD_EVICT_MODIFIED;
      ev_msg.val = line_cur.val;
    end else begin
      ev_msg.typ = CMD_EVICT_SHARED;
    end
  end

  // single-pass processing of the registered request
  always_comb begin
    line_d    = line_cur;
    dir_d     = dir_cur;
    mem_we    = 1'b0;
    mem_wdata = data_q;
    waiting_d = waiting_q;
    pend_d    = pend_q;
    n         = 3'd0;
    other     = dir_cur.bits & ~node_bit(snd_q) & 4'hF;
    left_bits = 4'd0;
    for (int k = 0; k < 4; k++) msgs[k] = '0;

    case (cmd_e'(cmd_q))
      CMD_READ_REQUEST: begin
        if (dir_cur.st == DIR_U) begin
          msgs[0] = '{CMD_REPLY_RD, snd_q, addr_q, mem_rd, 4'd0, 2'd0, DIR_EM};
          dir_d.st   = DIR_EM;
          dir_d.bits = node_bit(snd_q);
        end else if (dir_cur.st == DIR_S) begin
          msgs[0] = '{CMD_REPLY_RD, snd_q, addr_q, mem_rd, 4'd0, 2'd0, DIR_S};
          dir_d.bits = dir_cur.bits | node_bit(snd_q);
        end else begin
          msgs[0] = '{CMD_WRITEBACK_INT, lowest_node(dir_cur.bits), addr_q, 8'd0,
                      4'd0, snd_q, 2'd0};
        end
        n = 3'd1;
      end
      CMD_WRITE_REQUEST: begin
        if (dir_cur.st == DIR_U) begin
          msgs[0] = '{CMD_REPLY_WR, snd_q, addr_q, 8'd0, 4'd0, 2'd0, 2'd0};
        end else if (dir_cur.st == DIR_S) begin
          msgs[0] = '{CMD_REPLY_ID, snd_q, addr_q, 8'd0, other, 2'd0, 2'd0};
        end else begin
          msgs[0] = '{CMD_WB_INVALIDATE, lowest_node(dir_cur.bits), addr_q, data_q,
                      4'd0, snd_q, 2'd0};
        end
        n = 3'd1;
        dir_d.st   = DIR_EM;
        dir_d.bits = node_bit(snd_q);
      end
      CMD_REPLY_RD: begin
        if (ev_need) begin
          msgs[0] = ev_msg;
          n = 3'd1;
        end
        line_d = '{addr_q, data_q, (rds_q == DIR_S) ? LST_S : LST_E};
        waiting_d = 1'b0;
      end
      CMD_REPLY_WR: begin
        if (ev_need) begin
          msgs[0] = ev_msg;
          n = 3'd1;
        end
        line_d = '{addr_q, pend_q, LST_M};
        waiting_d = 1'b0;
      end
      CMD_REPLY_ID: begin
        // invalidations to every listed sharer except this node
        for (int i = 0; i < 4; i++) begin
          if ((i < NODE_COUNT) && shr_q[i] && (2'(i) != node_id_q)) begin
            msgs[n[1:0]] = '{CMD_INV, 2'(i), addr_q, 8'd0, 4'd0, 2'd0, 2'd0};
            n = n + 3'd1;
          end
        end
        if (ev_need) begin
          msgs[n[1:0]] = ev_msg;
          n = n + 3'd1;
        end
        line_d = '{addr_q, pend_q, LST_M};
        waiting_d = 1'b0;
      end
      CMD_INV: begin
        if (line_cur.addr == addr_q) line_d.st = LST_I;
      end
      CMD_UPGRADE: begin
        msgs[0] = '{CMD_REPLY_ID, snd_q, addr_q, 8'd0, other, 2'd0, 2'd0};
        n = 3'd1;
        dir_d.st   = DIR_EM;
        dir_d.bits = node_bit(snd_q);
      end
      CMD_WB_INVALIDATE: begin
        msgs[0] = '{CMD_FLUSH_INVACK, home[1:0], addr_q, line_cur.val, 4'd0, sr_q, 2'd0};
        msgs[1] = '{CMD_FLUSH_INVACK, sr_q, addr_q, line_cur.val, 4'd0, sr_q, 2'd0};
        n = 3'd2;
        line_d.st = LST_I;
      end
      CMD_WRITEBACK_INT: begin
        msgs[0] = '{CMD_FLUSH, home[1:0], addr_q, line_cur.val, 4'd0, sr_q, 2'd0};
        msgs[1] = '{CMD_FLUSH, sr_q, addr_q, line_cur.val, 4'd0, sr_q, 2'd0};
        n = (home != {2'd0, sr_q}) ? 3'd2 : 3'd1;
        line_d.st = LST_S;
      end
      CMD_FLUSH: begin
        if (home == {2'd0, node_id_q}) begin
          dir_d.st   = DIR_S;
          dir_d.bits = dir_cur.bits | node_bit(sr_q);
          mem_we     = 1'b1;
        end
        if (sr_q == node_id_q) begin
          if (ev_need) begin
            msgs[0] = ev_msg;
            n = 3'd1;
          end
          line_d = '{addr_q, data_q, LST_S};
        end
        waiting_d = 1'b0;
      end
      CMD_FLUSH_INVACK: begin
        if (home == {2'd0, node_id_q}) begin
          dir_d.bits = node_bit(sr_q);
          mem_we     = 1'b1;
        end
        if (sr_q == node_id_q) begin
          if (ev_need) begin
            msgs[0] = ev_msg;
            n = 3'd1;
          end
          line_d = '{addr_q, pend_q, LST_M};
        end
        waiting_d = 1'b0;
      end
      CMD_EVICT_SHARED: begin
        if (home == {2'd0, node_id_q}) begin
          left_bits  = dir_cur.bits & ~node_bit(snd_q) & 4'hF;
          dir_d.bits = left_bits;
          if (count_bits(left_bits) == 3'd0) begin
            dir_d.st = DIR_U;
          end else if (count_bits(left_bits) == 3'd1) begin
            dir_d.st = DIR_EM;
            msgs[0] = '{CMD_EVICT_SHARED, lowest_node(left_bits), addr_q, mem_rd,
                        4'd0, 2'd0, 2'd0};
            n = 3'd1;
          end
        end else if ((line_cur.addr == addr_q) && (line_cur.st == LST_S)) begin
          line_d.st = LST_E;
        end
      end
      CMD_EVICT_MODIFIED: begin
        mem_we = 1'b1;
        dir_d  = '{DIR_U, 4'd0};
      end
      CMD_LOCAL_READ: begin
        if (!waiting_q) begin
          pend_d = 8'd0;
          if (!hit) begin
            msgs[0] = '{CMD_READ_REQUEST, home[1:0], addr_q, 8'd0, 4'd0, 2'd0, 2'd0};
            n = 3'd1;
            waiting_d = 1'b1;
          end
        end
      end
      CMD_LOCAL_WRITE: begin
        if (!waiting_q) begin
          pend_d = data_q;
          if (hit && ((line_cur.st == LST_M) || (line_cur.st == LST_E))) begin
            line_d.val = data_q;
            line_d.st  = LST_M;
          end else begin
            msgs[0] = '{hit ? CMD_UPGRADE : CMD_WRITE_REQUEST, home[1:0], addr_q,
                        data_q, 4'd0, 2'd0, 2'd0};
            n = 3'd1;
            waiting_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // request register and node id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      node_id_q  <= 2'd0;
    end else begin
      in_valid_q <= accept;
      if (cfg_valid_i && cfg_ready_o) node_id_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      snd_q  <= sender_i;
      addr_q <= address_i;
      data_q <= data_value_i;
      shr_q  <= sharers_i;
      sr_q   <= second_receiver_i;
      rds_q  <= reply_dir_state_i;
    end
  end

  // cache, directory and control state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CACHE_LINE_COUNT; k++) line_q[k] <= '{ADDR_NONE, 8'd0, LST_I};
      for (int k = 0; k < MEMORY_BLOCKS; k++) begin
        dir_q[k]  <= '{DIR_U, 4'd0};
        memv_q[k] <= 1'b0;
      end
      waiting_q <= 1'b0;
      pend_q    <= 8'd0;
      left_q    <= 3'd0;
      optr_q    <= 2'd0;
    end else begin
      if (in_valid_q) begin
        line_q[li] <= line_d;
        dir_q[blk] <= dir_d;
        if (mem_we) memv_q[blk] <= 1'b1;
        waiting_q  <= waiting_d;
        pend_q     <= pend_d;
        left_q     <= n;
        optr_q     <= 2'd0;
      end else if (left_q != 3'd0) begin
        left_q <= left_q - 3'd1;
        optr_q <= optr_q + 2'd1;
      end
    end
  end

  // home memory data and message buffer payload
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      if (mem_we) mem_q[blk] <= mem_wdata;
      for (int k = 0; k < 4; k++) obuf_q[k] <= msgs[k];
    end
  end

  // drain the buffer one message per cycle
  assign out_valid_o           = (left_q != 3'd0);
  assign out_type_o            = obuf_q[optr_q].typ;
  assign destination_o         = obuf_q[optr_q].dest;
  assign out_address_o         = obuf_q[optr_q].addr;
  assign out_value_o           = obuf_q[optr_q].val;
  assign out_sharers_o         = obuf_q[optr_q].shr;
  assign out_second_receiver_o = obuf_q[optr_q].sr;
  assign out_dir_state_o       = obuf_q[optr_q].ds;
  assign last_o                = (left_q == 3'd1);

endmodule

FILE: rtl/core/dmnc_checker.sv
// dmnc_checker: port-level assertions for the coherence node controller
// depends on directory_mesi_node_controller ports; bound to the top level below
module dmnc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic out_valid_o,
  input logic last_o
);

  // the processing cycle follows an accept, no message shows in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !out_valid_o))
    else $error("no processing cycle after request accept");

  // messages of one request come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("gap inside a message burst");

  // after the last message the burst is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o)
    else $error("message after last");

  // a message only shows while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("message while idle");

endmodule

bind directory_mesi_node_controller dmnc_checker u_dmnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .out_valid_o (out_valid_o),
  .last_o      (last_o)
);
